/* hw/rtl/sorted_range_search_macros.svh */
// Assertion macros shared by the sorted range search RTL.
`ifndef SORTED_RANGE_SEARCH_MACROS_SVH
`define SORTED_RANGE_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/srs_pkg.sv */
// Types and constants shared by the sorted range search modules.
`default_nettype none

package srs_pkg;

    // Fixed field widths of the request and result ports.
    localparam int FIELD_W = 32;
    localparam int IDX_W   = 8;
    localparam int LEN_W   = 9;

    // Request kinds carried by the mode field.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS1,
        S_START2,
        S_PASS2,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_en;
        logic load_key;
        logic start;
        logic pass_high;
        logic probe;
        logic load_result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic more;
        logic hit;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/sorted_range_search.sv */
// Sorted range search: a store of signed values sorted ascending, searched for the
// first and last index of a key by two binary searches over the first array_length
// entries. A load request writes one entry and gives no result. Each pass of a query
// makes one probe per cycle and needs at most floor(log2(n)) + 1 probes over n
// entries; the second pass is skipped when the key is absent. The probe rate is
// set by the single read port of the store, which the search loop reads once per
// cycle. A new request is taken once the previous query has placed its result in
// the output register, and results not yet taken stall the next query at its last
// cycle. The store is not cleared at reset; searches must only cover loaded entries.
`default_nettype none

module sorted_range_search #(
    parameter int STORE_DEPTH = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic        [srs_pkg::LEN_W-1:0]    cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                mode,
    input  wire logic        [srs_pkg::IDX_W-1:0]    write_index,
    input  wire logic signed [srs_pkg::FIELD_W-1:0]  element_value,
    input  wire logic signed [srs_pkg::FIELD_W-1:0]  search_key,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     found,
    output logic             [srs_pkg::IDX_W-1:0]    first_index,
    output logic             [srs_pkg::IDX_W-1:0]    last_index,
    output logic             [srs_pkg::LEN_W-1:0]    occurrence_count
);

    srs_pkg::cmd_t    cmd;
    srs_pkg::status_t status;

    // The length register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer for loads and the two search passes.
    srs_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Store, bounds and result registers.
    srs_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .write_index      (write_index),
        .element_value    (element_value),
        .search_key       (search_key),
        .found            (found),
        .first_index      (first_index),
        .last_index       (last_index),
        .occurrence_count (occurrence_count)
    );

endmodule

`default_nettype wire

/* hw/rtl/srs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/srs_datapath.sv */
// Datapath: value store, search bounds, probe compare and result registers.
`default_nettype none

module srs_datapath #(
    parameter int STORE_DEPTH = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire srs_pkg::cmd_t                       cmd,
    output srs_pkg::status_t                         status,
    input  wire logic                                cfg_write,
    input  wire logic        [srs_pkg::LEN_W-1:0]    cfg_data,
    input  wire logic        [srs_pkg::IDX_W-1:0]    write_index,
    input  wire logic signed [srs_pkg::FIELD_W-1:0]  element_value,
    input  wire logic signed [srs_pkg::FIELD_W-1:0]  search_key,
    output logic                                     found,
    output logic             [srs_pkg::IDX_W-1:0]    first_index,
    output logic             [srs_pkg::IDX_W-1:0]    last_index,
    output logic             [srs_pkg::LEN_W-1:0]    occurrence_count
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = srs_pkg::LEN_W;

    logic        [LW-1:0]          array_length_reg;
    logic signed [VALUE_WIDTH-1:0] key_reg;
    logic        [LW-1:0]          n_reg;
    logic        [LW-1:0]          lo_reg, lo_next;
    logic        [LW-1:0]          hip1_reg, hip1_next;
    logic        [LW-1:0]          mid_reg, mid_next;
    logic        [LW-1:0]          pos_reg, pos_next;
    logic                          hit_reg, hit_next;
    logic                          pass_reg;
    logic        [LW-1:0]          first_reg;
    logic                          f1_reg;
    logic        [LW-1:0]          n_clamp;
    logic        [LW-1:0]          n_src;
    logic        [LW:0]            mid_sum;
    logic                          ram_we;
    logic        [VALUE_WIDTH-1:0] ram_rdata;
    logic signed [VALUE_WIDTH-1:0] probe_value;
    logic                          found_reg;
    logic        [LW-1:0]          first_out_reg;
    logic        [LW-1:0]          last_out_reg;
    logic        [LW-1:0]          count_reg;

    // Length register, written from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            array_length_reg <= cfg_data;
        end
    end

    // A length beyond the store searches the whole store.
    assign n_clamp = (32'(array_length_reg) > STORE_DEPTH) ? LW'(STORE_DEPTH)
                                                           : array_length_reg;
    assign n_src   = cmd.pass_high ? n_reg : n_clamp;

    // Loads outside the store are dropped.
    assign ram_we = cmd.write_en && (32'(write_index) < STORE_DEPTH);

    assign probe_value = $signed(ram_rdata);

    // Bound update: start of a pass or one probe of the element read last cycle.
    always_comb
    begin
        lo_next   = lo_reg;
        hip1_next = hip1_reg;
        pos_next  = pos_reg;
        hit_next  = hit_reg;
        if (cmd.start)
        begin
            lo_next   = '0;
            hip1_next = n_src;
            pos_next  = '0;
            hit_next  = 1'b0;
        end
        else if (cmd.probe)
        begin
            if (key_reg == probe_value)
            begin
                hit_next = 1'b1;
                pos_next = mid_reg;
                if (pass_reg)
                begin
                    lo_next = mid_reg + LW'(1);
                end
                else
                begin
                    hip1_next = mid_reg;
                end
            end
            else if (key_reg < probe_value)
            begin
                hip1_next = mid_reg;
            end
            else
            begin
                lo_next = mid_reg + LW'(1);
            end
        end
    end

    // Midpoint of the next interval drives the read address directly.
    assign mid_sum  = {1'b0, lo_next} + {1'b0, hip1_next} - (LW + 1)'(1);
    assign mid_next = mid_sum[LW:1];

    assign status.more = lo_next < hip1_next;
    assign status.hit  = hit_next;

    // Search state registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= VALUE_WIDTH'(search_key);
            n_reg   <= n_clamp;
        end
        if (cmd.start)
        begin
            pass_reg <= cmd.pass_high;
        end
        if (cmd.start || cmd.probe)
        begin
            lo_reg   <= lo_next;
            hip1_reg <= hip1_next;
            pos_reg  <= pos_next;
            hit_reg  <= hit_next;
            mid_reg  <= mid_next;
        end
        // The low-edge pass leaves its outcome here as it goes.
        if ((cmd.start && !cmd.pass_high) || (cmd.probe && !pass_reg))
        begin
            first_reg <= pos_next;
            f1_reg    <= hit_next;
        end
    end

    // Result registers, loaded once the search is over.
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            if (f1_reg && hit_reg && (pos_reg >= first_reg))
            begin
                found_reg     <= 1'b1;
                first_out_reg <= first_reg;
                last_out_reg  <= pos_reg;
                count_reg     <= pos_reg - first_reg + LW'(1);
            end
            else
            begin
                found_reg     <= 1'b0;
                first_out_reg <= '0;
                last_out_reg  <= '0;
                count_reg     <= '0;
            end
        end
    end

    assign found            = found_reg;
    assign first_index      = first_out_reg[srs_pkg::IDX_W-1:0];
    assign last_index       = last_out_reg[srs_pkg::IDX_W-1:0];
    assign occurrence_count = count_reg;

    // Sorted value store.
    srs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(write_index)),
        .wdata (VALUE_WIDTH'(element_value)),
        .raddr (AW'(mid_next)),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/srs_controller.sv */
// Controller: request intake, the two search passes and result hand-off.
`default_nettype none

`include "sorted_range_search_macros.svh"

module srs_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             mode,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output srs_pkg::cmd_t         cmd,
    input  wire srs_pkg::status_t status
);

    srs_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = (state_reg == srs_pkg::S_IDLE);
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            srs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == srs_pkg::MODE_QUERY)
                    begin
                        cmd.load_key = 1'b1;
                        cmd.start    = 1'b1;
                        state_next   = status.more ? srs_pkg::S_PASS1 : srs_pkg::S_FINISH;
                    end
                    else
                    begin
                        cmd.write_en = 1'b1;
                    end
                end
            end
            srs_pkg::S_PASS1:
            begin
                cmd.probe = 1'b1;
                if (!status.more)
                begin
                    // An absent key needs no second pass.
                    state_next = status.hit ? srs_pkg::S_START2 : srs_pkg::S_FINISH;
                end
            end
            srs_pkg::S_START2:
            begin
                cmd.start     = 1'b1;
                cmd.pass_high = 1'b1;
                state_next    = status.more ? srs_pkg::S_PASS2 : srs_pkg::S_FINISH;
            end
            srs_pkg::S_PASS2:
            begin
                cmd.probe = 1'b1;
                if (!status.more)
                begin
                    state_next = srs_pkg::S_FINISH;
                end
            end
            srs_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = srs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srs_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // A loaded result is offered on the next cycle.
    `SRS_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.load_result, out_valid_reg,
        "loaded result not offered")
    // The second pass only starts after a hit, so its interval is never empty.
    `SRS_ASSERT_IMPLY(a_pass2_nonempty, clk, rst_n, state_reg == srs_pkg::S_START2,
        status.more, "second pass started on an empty interval")
    // The store is never written while a search is probing it.
    `SRS_ASSERT_IMPLY(a_no_write_in_search, clk, rst_n, cmd.probe || cmd.start,
        !cmd.write_en, "store write during a search")

endmodule

`default_nettype wire

/* sim/srs_checker.sv */
// Checker for the sorted range search: watches all channels, predicts each query and compares.
module srs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [srs_pkg::LEN_W-1:0]           cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                mode,
    input  logic [srs_pkg::IDX_W-1:0]           write_index,
    input  logic signed [srs_pkg::FIELD_W-1:0]  element_value,
    input  logic signed [srs_pkg::FIELD_W-1:0]  search_key,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                found,
    input  logic [srs_pkg::IDX_W-1:0]           first_index,
    input  logic [srs_pkg::IDX_W-1:0]           last_index,
    input  logic [srs_pkg::LEN_W-1:0]           occurrence_count,
    output int                                  fail_count,
    output int                                  outstanding
);

    localparam int DEPTH = 256;

    typedef struct packed {
        logic                      found;
        logic [srs_pkg::IDX_W-1:0] first;
        logic [srs_pkg::IDX_W-1:0] last;
        logic [srs_pkg::LEN_W-1:0] count;
    } key_range_t;

    // Shadow copy of the store and the length register.
    logic signed [srs_pkg::FIELD_W-1:0] shadow_store [DEPTH];
    logic [srs_pkg::LEN_W-1:0]          shadow_length;

    // Predicted ranges of queries whose result has not come back yet.
    key_range_t pending_ranges [$];
    key_range_t want;
    int         errors;

    initial
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            shadow_store[k] = '0;
        end
        shadow_length = '0;
        errors        = 0;
    end

    // One edge of a binary search over the first n entries.
    function automatic bit find_edge(input logic signed [srs_pkg::FIELD_W-1:0] key,
                                     input int n, input bit toward_high, output int pos);
        int lo;
        int hi;
        int mid;
        bit hit;
        lo  = 0;
        hi  = n - 1;
        hit = 1'b0;
        pos = 0;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key == shadow_store[mid])
            begin
                hit = 1'b1;
                pos = mid;
                if (toward_high)
                begin
                    lo = mid + 1;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
            else if (key < shadow_store[mid])
            begin
                hi = mid - 1;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        return hit;
    endfunction

    // Equal range of a key; an absent key or an inconsistent pair gives all zeros.
    function automatic key_range_t predict_range(
        input logic signed [srs_pkg::FIELD_W-1:0] key);
        int         n;
        int         lo_pos;
        int         hi_pos;
        bit         lo_hit;
        bit         hi_hit;
        key_range_t r;
        n      = (shadow_length > DEPTH) ? DEPTH : int'(shadow_length);
        lo_hit = find_edge(key, n, 1'b0, lo_pos);
        hi_hit = find_edge(key, n, 1'b1, hi_pos);
        r      = '0;
        if (lo_hit && hi_hit && hi_pos >= lo_pos)
        begin
            r.found = 1'b1;
            r.first = lo_pos[srs_pkg::IDX_W-1:0];
            r.last  = hi_pos[srs_pkg::IDX_W-1:0];
            r.count = srs_pkg::LEN_W'(hi_pos - lo_pos + 1);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
            errors++;
        end
    endtask

    // Results are checked before new requests are predicted, so a result can
    // only ever match a query accepted at an earlier edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            shadow_length = '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_ranges.size() == 0)
                begin
                    $display({"%0t: result with no query waiting, expected none, ",
                              "actual %0d/%0d/%0d/%0d"},
                             $time, found, first_index, last_index, occurrence_count);
                    errors++;
                end
                else
                begin
                    want = pending_ranges.pop_front();
                    check_field("found", want.found, found);
                    check_field("first_index", want.first, first_index);
                    check_field("last_index", want.last, last_index);
                    check_field("occurrence_count", want.count, occurrence_count);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                shadow_length = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                if (mode == srs_pkg::MODE_LOAD)
                begin
                    shadow_store[write_index] = element_value;
                end
                else
                begin
                    pending_ranges.push_back(predict_range(search_key));
                end
            end
        end
        fail_count  <= errors;
        outstanding <= pending_ranges.size();
    end

endmodule

/* sim/tb_top.sv */
// Testbench top for the sorted range search: clock, reset, request stimulus and verdict.
module tb_top;

    localparam int DEPTH         = 256;
    localparam int ITEM_TARGET   = 1700;
    localparam int SETTLE_CYCLES = 30;
    localparam int LIMIT_CYCLES  = 600000;

    localparam logic signed [srs_pkg::FIELD_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [srs_pkg::FIELD_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic                               clk              = 1'b0;
    logic                               rst_n            = 1'b0;
    logic                               cfg_valid        = 1'b0;
    logic                               cfg_ready;
    logic [srs_pkg::LEN_W-1:0]          cfg_data         = '0;
    logic                               in_valid         = 1'b0;
    logic                               in_ready;
    logic                               mode             = srs_pkg::MODE_LOAD;
    logic [srs_pkg::IDX_W-1:0]          write_index      = '0;
    logic signed [srs_pkg::FIELD_W-1:0] element_value    = '0;
    logic signed [srs_pkg::FIELD_W-1:0] search_key       = '0;
    logic                               out_valid;
    logic                               out_ready        = 1'b0;
    logic                               found;
    logic [srs_pkg::IDX_W-1:0]          first_index;
    logic [srs_pkg::IDX_W-1:0]          last_index;
    logic [srs_pkg::LEN_W-1:0]          occurrence_count;
    int                                 fail_count;
    int                                 outstanding;

    // Values the stimulus has loaded, used only to pick meaningful keys.
    logic signed [srs_pkg::FIELD_W-1:0] loaded_values [DEPTH];
    int                                 burst_left = 0;
    int                                 items_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_range_search uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .write_index      (write_index),
        .element_value    (element_value),
        .search_key       (search_key),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .found            (found),
        .first_index      (first_index),
        .last_index       (last_index),
        .occurrence_count (occurrence_count)
    );

    srs_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .write_index      (write_index),
        .element_value    (element_value),
        .search_key       (search_key),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .found            (found),
        .first_index      (first_index),
        .last_index       (last_index),
        .occurrence_count (occurrence_count),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    // Result side stalls in segments: always ready, random, mostly stalled, or long runs.
    int ready_mode = 0;
    int segment_left = 0;
    int run_left = 0;

    always @(posedge clk)
    begin
        if (segment_left == 0)
        begin
            ready_mode   = $urandom_range(0, 3);
            segment_left = $urandom_range(20, 200);
        end
        segment_left--;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default:
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(1, 30);
                    out_ready <= ~out_ready;
                end
                run_left--;
            end
        endcase
    end

    // Send one request; the sender runs in bursts with random gaps between them.
    // Returns at the edge where the request was accepted.
    task automatic send_req(input logic m, input logic [srs_pkg::IDX_W-1:0] idx,
                            input logic signed [srs_pkg::FIELD_W-1:0] value,
                            input logic signed [srs_pkg::FIELD_W-1:0] key);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid      <= 1'b1;
        mode          <= m;
        write_index   <= idx;
        element_value <= value;
        search_key    <= key;
        do @(posedge clk); while (!(in_valid && in_ready));
        items_sent++;
    endtask

    task automatic load_entry(input int idx,
                              input logic signed [srs_pkg::FIELD_W-1:0] value);
        loaded_values[idx] = value;
        send_req(srs_pkg::MODE_LOAD, srs_pkg::IDX_W'(idx), value, $urandom());
    endtask

    task automatic query(input logic signed [srs_pkg::FIELD_W-1:0] key);
        send_req(srs_pkg::MODE_QUERY, srs_pkg::IDX_W'($urandom()), $urandom(), key);
    endtask

    // Drain all queries, give the block time to finish, then write the length.
    task automatic set_length(input int len);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= srs_pkg::LEN_W'(len);
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // Load entries 0..count-1 with ascending values, rich in duplicates.
    task automatic fill_sorted(input int count);
        longint v;
        longint delta;
        int     sel;
        v = ($urandom_range(0, 3) == 0) ? longint'(VALUE_MIN) : longint'($signed($urandom()));
        for (int k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 9);
            if (k == 0 || sel < 3)
            begin
                delta = 0;
            end
            else if (sel < 8)
            begin
                delta = $urandom_range(1, 1000);
            end
            else
            begin
                delta = $urandom_range(1, 1 << 24);
            end
            v = v + delta;
            if (v > longint'(VALUE_MAX))
            begin
                v = longint'(VALUE_MAX);
            end
            load_entry(k, v[srs_pkg::FIELD_W-1:0]);
        end
    endtask

    // Keys: mostly present in range, plus neighbors, out-of-range entries, extremes and random values.
    function automatic logic signed [srs_pkg::FIELD_W-1:0] pick_key(input int n);
        int sel;
        sel = $urandom_range(0, 99);
        if (n > 0 && sel < 50)
        begin
            return loaded_values[$urandom_range(0, n - 1)];
        end
        if (n > 0 && sel < 65)
        begin
            return loaded_values[$urandom_range(0, n - 1)] +
                   ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        end
        if (sel < 75)
        begin
            return loaded_values[$urandom_range(0, DEPTH - 1)];
        end
        if (sel < 85)
        begin
            return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
        end
        return $urandom();
    endfunction

    // Ends the run if the block stops making progress.
    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("FAIL sorted_range_search");
        $finish;
    end

    initial
    begin
        int len;
        int n;
        int sel;

        for (int k = 0; k < DEPTH; k++)
        begin
            loaded_values[k] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Length is zero after reset, so nothing can be found.
        query(32'sd0);

        // Full store: extremes at both ends, pairs of equal values, one long run of 7.
        for (int k = 0; k < DEPTH; k++)
        begin
            if (k == 0)
            begin
                load_entry(k, VALUE_MIN);
            end
            else if (k == DEPTH - 1)
            begin
                load_entry(k, VALUE_MAX);
            end
            else if (k >= 100 && k <= 140)
            begin
                load_entry(k, 32'sd7);
            end
            else
            begin
                load_entry(k, ((k - 128) / 2) * 1000);
            end
        end

        set_length(DEPTH);
        query(VALUE_MIN);
        query(VALUE_MAX);
        query(32'sd7);
        query(-32'sd15000);
        query(32'sd0);
        query(VALUE_MIN + 32'sd1);
        query(VALUE_MAX - 32'sd1);

        // A length above the store depth searches the whole store.
        set_length(511);
        query(VALUE_MAX);
        query(32'sd7);

        // The last entry falls outside the searched range.
        set_length(DEPTH - 1);
        query(VALUE_MAX);

        set_length(1);
        query(VALUE_MIN);
        query(32'sd7);

        set_length(2);
        query(loaded_values[1]);

        // Random phases, each with its own length and mostly freshly sorted contents.
        while (items_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 31);
            case (sel)
                0: len = 0;
                1: len = 1;
                2: len = 2;
                3: len = DEPTH;
                4: len = $urandom_range(DEPTH + 1, 511);
                5: len = DEPTH - 1;
                6: len = 511;
                7: len = $urandom_range(41, DEPTH - 2);
                default: len = $urandom_range(3, 40);
            endcase
            n = (len > DEPTH) ? DEPTH : len;
            set_length(len);
            // Large ranges are refilled only half the time; otherwise the store
            // is left partly unsorted.
            if (n > 0 && (n <= 40 || $urandom_range(0, 1) == 1))
            begin
                fill_sorted((n + 4 > DEPTH) ? DEPTH : n + $urandom_range(0, 4));
            end
            repeat ($urandom_range(15, 40))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    load_entry($urandom_range(0, DEPTH - 1), $urandom());
                end
                else
                begin
                    query(pick_key(n));
                end
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS sorted_range_search");
        end
        else
        begin
            $display("FAIL sorted_range_search");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/srs_pkg.sv
hw/rtl/srs_ram.sv
hw/rtl/srs_datapath.sv
hw/rtl/srs_controller.sv
hw/rtl/sorted_range_search.sv
sim/srs_checker.sv
sim/tb_top.sv
